[sv/fdsm_pkg.sv]
// ----------------------------------------------------------------------------
// Fall detector package
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package fdsm_pkg;

   localparam int WINDOW = 64;
   localparam int WIN_AW = $clog2(WINDOW);
   localparam int SUM_W  = 16 + WIN_AW;
   localparam int SQ_W   = 32 + WIN_AW;
   localparam int MUL_W  = SUM_W;
   localparam int CMP_W  = 2 * MUL_W;
   localparam int ROOT_STEPS = 16;
   localparam int CNT_W  = $clog2(ROOT_STEPS);

   localparam logic [15:0] FREE_FALL_LEVEL_RST = 16'd2048;
   localparam logic [15:0] IMPACT_LEVEL_RST    = 16'd12288;
   localparam logic [31:0] POST_WAIT_RST       = 32'd2000;
   localparam logic [31:0] FF_TIMEOUT_RST      = 32'd2000;
   localparam logic [31:0] HOLD_RST            = 32'd10000;
   localparam logic [31:0] QUIET_LIMIT_RST     = 32'd167772;

   typedef enum logic [2:0] {
      REG_FREE_FALL_LEVEL = 3'd0,
      REG_IMPACT_LEVEL    = 3'd1,
      REG_POST_WAIT       = 3'd2,
      REG_FF_TIMEOUT      = 3'd3,
      REG_ALERT_HOLD      = 3'd4,
      REG_QUIET_LIMIT     = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_NORMAL    = 3'd0,
      PH_FREE_FALL = 3'd1,
      PH_IMPACT    = 3'd2,
      PH_POST_FALL = 3'd3,
      PH_CONFIRMED = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      MUL_X   = 3'd0,
      MUL_Y   = 3'd1,
      MUL_Z   = 3'd2,
      MUL_MAG = 3'd3,
      MUL_OLD = 3'd4,
      MUL_SUM = 3'd5
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        acc_en;
      logic        root_init;
      logic        root_step;
      logic        cap_magsq;
      logic        cap_oldsq;
      logic        upd;
      logic        cap_s2;
      logic        decide;
   } ctl_cmd_type;

   typedef struct packed {
      logic func;
   } ctl_sts_type;

endpackage

[sv/fdsm_if.sv]
// ----------------------------------------------------------------------------
// Fall detector channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface fdsm_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [31:0]        time_ms;
   modport source (output valid, func, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink   (input valid, func, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface fdsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  detector_state;
   logic        falling;
   logic        fallen;
   logic [15:0] accel_magnitude;
   logic [31:0] falls_total;
   logic [31:0] false_alarms_total;
   modport source (output valid, detector_state, falling, fallen, accel_magnitude,
                   falls_total, false_alarms_total, input ready);
   modport sink   (input valid, detector_state, falling, fallen, accel_magnitude,
                   falls_total, false_alarms_total, output ready);
endinterface

interface fdsm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/fall_detector_state_machine.sv]
// ----------------------------------------------------------------------------
// Fall detector state machine
// Magnitude, windowed variance and five-phase fall detection per sample.
//
//   channel  direction  contents
//   req_bus  in         func, accel_x/y/z, time_ms
//   rsp_bus  out        detector_state, falling, fallen, accel_magnitude, totals
//   csr_bus  in         index, data (always ready)
//
// From accept to response valid a sample passes 3 squaring steps, 16 square-root
// iterations, squaring the new and oldest magnitude, window update, variance and
// decide; a reset request skips to decide. One request is in flight; the next is
// accepted the cycle after the response is taken. Synchronous reset clears the
// window through per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module fall_detector_state_machine
   import fdsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fdsm_req_if.sink   req_bus,
   fdsm_rsp_if.source rsp_bus,
   fdsm_csr_if.sink   csr_bus
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_bus.ready = 1'b1;

   fdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fdsm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .func               (req_bus.func),
      .accel_x            (req_bus.accel_x),
      .accel_y            (req_bus.accel_y),
      .accel_z            (req_bus.accel_z),
      .time_ms            (req_bus.time_ms),
      .cfg_we             (csr_bus.valid),
      .cfg_index          (csr_bus.index),
      .cfg_data           (csr_bus.data),
      .detector_state     (rsp_bus.detector_state),
      .falling            (rsp_bus.falling),
      .fallen             (rsp_bus.fallen),
      .accel_magnitude    (rsp_bus.accel_magnitude),
      .falls_total        (rsp_bus.falls_total),
      .false_alarms_total (rsp_bus.false_alarms_total)
   );

`ifndef SYNTHESIS
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !rsp_bus.valid)
      else $error("response valid right after accept");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.falling && rsp_bus.fallen))
      else $error("falling and fallen both set");
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready) |=> req_bus.ready)
      else $error("not ready after response taken");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("ready while response pending");
`endif

endmodule

[sv/fdsm_ctrl.sv]
// ----------------------------------------------------------------------------
// Fall detector controller
// Sequences squaring, square root, window update and the phase decision.
// ----------------------------------------------------------------------------
module fdsm_ctrl
   import fdsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_SQX  = 11'b00000000010,
      ST_SQY  = 11'b00000000100,
      ST_SQZ  = 11'b00000001000,
      ST_ROOT = 11'b00000010000,
      ST_SQM  = 11'b00000100000,
      ST_SQO  = 11'b00001000000,
      ST_UPD  = 11'b00010000000,
      ST_VAR  = 11'b00100000000,
      ST_DEC  = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_X;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            // reset request skips straight to the decision
            if (sts.func) begin
               state_in = ST_DEC;
            end else begin
               cmd.mul_sel = MUL_X;
               cmd.acc_en  = 1'b1;
               state_in    = ST_SQY;
            end
         end
         ST_SQY: begin
            cmd.mul_sel = MUL_Y;
            cmd.acc_en  = 1'b1;
            state_in    = ST_SQZ;
         end
         ST_SQZ: begin
            cmd.mul_sel   = MUL_Z;
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = ST_SQM;
            end
         end
         ST_SQM: begin
            cmd.mul_sel   = MUL_MAG;
            cmd.cap_magsq = 1'b1;
            state_in      = ST_SQO;
         end
         ST_SQO: begin
            cmd.mul_sel   = MUL_OLD;
            cmd.cap_oldsq = 1'b1;
            state_in      = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            cmd.mul_sel = MUL_SUM;
            cmd.cap_s2  = 1'b1;
            state_in    = ST_DEC;
         end
         ST_DEC: begin
            cmd.decide = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

endmodule

[sv/fdsm_dpath.sv]
// ----------------------------------------------------------------------------
// Fall detector datapath
// Shared multiplier, square root, magnitude window and detector phase.
// ----------------------------------------------------------------------------
module fdsm_dpath
   import fdsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output ctl_sts_type        sts,
   input  logic               func,
   input  logic signed [15:0] accel_x,
   input  logic signed [15:0] accel_y,
   input  logic signed [15:0] accel_z,
   input  logic [31:0]        time_ms,
   input  logic               cfg_we,
   input  logic [2:0]         cfg_index,
   input  logic [31:0]        cfg_data,
   output logic [2:0]         detector_state,
   output logic               falling,
   output logic               fallen,
   output logic [15:0]        accel_magnitude,
   output logic [31:0]        falls_total,
   output logic [31:0]        false_alarms_total
);

   // configuration
   logic [15:0] ff_level_ff, impact_level_ff;
   logic [31:0] post_wait_ff, ff_timeout_ff, hold_ff, limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_level_ff     <= FREE_FALL_LEVEL_RST;
         impact_level_ff <= IMPACT_LEVEL_RST;
         post_wait_ff    <= POST_WAIT_RST;
         ff_timeout_ff   <= FF_TIMEOUT_RST;
         hold_ff         <= HOLD_RST;
         limit_ff        <= QUIET_LIMIT_RST;
      end else if (cfg_we) begin
         case (cfg_index)
            REG_FREE_FALL_LEVEL: ff_level_ff     <= cfg_data[15:0];
            REG_IMPACT_LEVEL:    impact_level_ff <= cfg_data[15:0];
            REG_POST_WAIT:       post_wait_ff    <= cfg_data;
            REG_FF_TIMEOUT:      ff_timeout_ff   <= cfg_data;
            REG_ALERT_HOLD:      hold_ff         <= cfg_data;
            REG_QUIET_LIMIT:     limit_ff        <= cfg_data;
            default: ;
         endcase
      end
   end

   // captured request
   logic        func_ff;
   logic [15:0] ax_ff, ay_ff, az_ff;
   logic [31:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func;
         ax_ff   <= accel_x[15] ? 16'(-accel_x) : accel_x;
         ay_ff   <= accel_y[15] ? 16'(-accel_y) : accel_y;
         az_ff   <= accel_z[15] ? 16'(-accel_z) : accel_z;
         now_ff  <= time_ms;
      end
   end

   assign sts.func = func_ff;

   // window storage
   logic [WIN_AW-1:0] wp_ff;
   logic [WINDOW-1:0] vld_ff;
   logic [15:0]       mem [WINDOW];
   logic [15:0]       rd_ff;
   logic [15:0]       old_mag;
   logic [15:0]       mag;

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         mem[wp_ff] <= mag;
      end
      rd_ff <= mem[wp_ff];
   end

   assign old_mag = vld_ff[wp_ff] ? rd_ff : 16'd0;

   // shared multiplier
   logic [MUL_W-1:0] mul_a;
   logic [CMP_W-1:0] prod;
   logic [SUM_W-1:0] sum_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_X:   mul_a = MUL_W'(ax_ff);
         MUL_Y:   mul_a = MUL_W'(ay_ff);
         MUL_Z:   mul_a = MUL_W'(az_ff);
         MUL_MAG: mul_a = MUL_W'(mag);
         MUL_OLD: mul_a = MUL_W'(old_mag);
         MUL_SUM: mul_a = MUL_W'(sum_ff);
         default: mul_a = '0;
      endcase
      prod = CMP_W'(mul_a) * CMP_W'(mul_a);
   end

   // sum of squares and square root
   logic [31:0] acc_ff, rem_ff, root_ff, bit_ff;
   logic [31:0] trial;

   assign trial = root_ff + bit_ff;
   assign mag   = root_ff[15:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + prod[31:0];
      end
      if (cmd.root_init) begin
         rem_ff  <= acc_ff + prod[31:0];
         root_ff <= '0;
         bit_ff  <= 32'h4000_0000;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // running window statistics
   logic [31:0]      magsq_ff, oldsq_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [CMP_W-1:0] s2_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_magsq) begin
         magsq_ff <= prod[31:0];
      end
      if (cmd.cap_oldsq) begin
         oldsq_ff <= prod[31:0];
      end
      if (cmd.cap_s2) begin
         s2_ff <= prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         vld_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else if (cmd.upd) begin
         vld_ff[wp_ff] <= 1'b1;
         sum_ff <= sum_ff - SUM_W'(old_mag) + SUM_W'(mag);
         sq_ff  <= sq_ff - SQ_W'(oldsq_ff) + SQ_W'(magsq_ff);
         wp_ff  <= (wp_ff == WIN_AW'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
      end
   end

   // quiet test: N*Q - S*S < limit*N*N
   logic [CMP_W-1:0] nq, spread, lim_n2;
   logic             quiet;

   always_comb begin
      nq     = CMP_W'(sq_ff) * CMP_W'(WINDOW);
      spread = (nq >= s2_ff) ? nq - s2_ff : '0;
      lim_n2 = CMP_W'(limit_ff) * CMP_W'(WINDOW * WINDOW);
      quiet  = spread < lim_n2;
   end

   // detector phase
   phase_type   phase_ff, phase_in;
   logic [31:0] start_ff, start_in, falls_ff, falls_in, alarms_ff, alarms_in;
   logic [31:0] elapsed;
   logic [15:0] mag_out_ff;

   assign elapsed = now_ff - start_ff;

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      falls_in  = falls_ff;
      alarms_in = alarms_ff;
      if (func_ff) begin
         phase_in = PH_NORMAL;
         start_in = '0;
      end else begin
         case (phase_ff)
            PH_NORMAL: begin
               if (mag < ff_level_ff) begin
                  phase_in = PH_FREE_FALL;
                  start_in = now_ff;
               end
            end
            PH_FREE_FALL: begin
               if (mag > impact_level_ff) begin
                  phase_in = PH_IMPACT;
                  start_in = now_ff;
               end else if (elapsed > ff_timeout_ff) begin
                  phase_in  = PH_NORMAL;
                  alarms_in = alarms_ff + 1'b1;
               end
            end
            PH_IMPACT: begin
               phase_in = PH_POST_FALL;
               start_in = now_ff;
            end
            PH_POST_FALL: begin
               if (!quiet) begin
                  phase_in  = PH_NORMAL;
                  alarms_in = alarms_ff + 1'b1;
               end else if (elapsed > post_wait_ff) begin
                  phase_in = PH_CONFIRMED;
                  falls_in = falls_ff + 1'b1;
               end
            end
            PH_CONFIRMED: begin
               if (elapsed > hold_ff) begin
                  phase_in = PH_NORMAL;
               end
            end
            default: begin
               phase_in = PH_NORMAL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORMAL;
         start_ff  <= '0;
         falls_ff  <= '0;
         alarms_ff <= '0;
      end else if (cmd.decide) begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         falls_ff  <= falls_in;
         alarms_ff <= alarms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         mag_out_ff <= func_ff ? 16'd0 : mag;
      end
   end

   assign detector_state     = phase_ff;
   assign falling            = (phase_ff == PH_FREE_FALL) || (phase_ff == PH_IMPACT);
   assign fallen             = (phase_ff == PH_CONFIRMED);
   assign accel_magnitude    = mag_out_ff;
   assign falls_total        = falls_ff;
   assign false_alarms_total = alarms_ff;

endmodule

[tb/sv/tb_fall_detector_state_machine.sv]
// ----------------------------------------------------------------------------
// Fall detector testbench
// Drives sample and reset requests with random gaps and stalls, predicts each
// response from an in-house model of the detector, and compares field by field.
// ----------------------------------------------------------------------------
module tb_fall_detector_state_machine;
   import fdsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  detector_state;
      logic        falling;
      logic        fallen;
      logic [15:0] accel_magnitude;
      logic [31:0] falls_total;
      logic [31:0] false_alarms_total;
   } verdict_type;

   logic clock;
   logic reset;
   fdsm_req_if req_bus ();
   fdsm_rsp_if rsp_bus ();
   fdsm_csr_if csr_bus ();

   fall_detector_state_machine u_top (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   // predictor state
   logic [15:0] lvl_free_fall, lvl_impact;
   logic [31:0] wait_post, timeout_ff, hold_alert, limit_quiet;
   logic [15:0] mag_hist [WINDOW];
   int          hist_ptr;
   logic [63:0] mag_sum, mag_sq_sum;
   phase_type   cur_phase;
   logic [31:0] phase_t0, fall_cnt, false_cnt;

   verdict_type pending_verdicts [$];
   int          errors;
   int          responses_seen;
   int          stall_long;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] floor_root(logic [31:0] v);
      logic [31:0] r, b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r[15:0];
   endfunction

   function automatic verdict_type detect_step(logic func, logic signed [15:0] ax,
         logic signed [15:0] ay, logic signed [15:0] az, logic [31:0] now);
      verdict_type v;
      logic [31:0] sq, dt;
      logic [15:0] mag, old;
      logic [63:0] nq, s2, spread;
      bit quiet;
      mag = 0;
      if (func) begin
         cur_phase = PH_NORMAL;
         phase_t0 = 0;
      end else begin
         sq = 32'(ax * ax) + 32'(ay * ay) + 32'(az * az);
         mag = floor_root(sq);
         old = mag_hist[hist_ptr];
         mag_sum = mag_sum - old + mag;
         mag_sq_sum = mag_sq_sum - 64'(old) * old + 64'(mag) * mag;
         mag_hist[hist_ptr] = mag;
         hist_ptr = (hist_ptr + 1) % WINDOW;
         dt = now - phase_t0;
         case (cur_phase)
            PH_NORMAL: if (mag < lvl_free_fall) begin
               cur_phase = PH_FREE_FALL;
               phase_t0 = now;
            end
            PH_FREE_FALL: if (mag > lvl_impact) begin
               cur_phase = PH_IMPACT;
               phase_t0 = now;
            end else if (dt > timeout_ff) begin
               cur_phase = PH_NORMAL;
               false_cnt++;
            end
            PH_IMPACT: begin
               cur_phase = PH_POST_FALL;
               phase_t0 = now;
            end
            PH_POST_FALL: begin
               nq = 64'(WINDOW) * mag_sq_sum;
               s2 = mag_sum * mag_sum;
               spread = (nq >= s2) ? nq - s2 : 0;
               quiet = spread < 64'(limit_quiet) * WINDOW * WINDOW;
               if (!quiet) begin
                  cur_phase = PH_NORMAL;
                  false_cnt++;
               end else if (dt > wait_post) begin
                  cur_phase = PH_CONFIRMED;
                  fall_cnt++;
               end
            end
            PH_CONFIRMED: if (dt > hold_alert) cur_phase = PH_NORMAL;
            default: cur_phase = PH_NORMAL;
         endcase
      end
      v.detector_state = cur_phase;
      v.falling = (cur_phase == PH_FREE_FALL || cur_phase == PH_IMPACT);
      v.fallen = (cur_phase == PH_CONFIRMED);
      v.accel_magnitude = mag;
      v.falls_total = fall_cnt;
      v.false_alarms_total = false_cnt;
      return v;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // random ready or hold on the response side, or a counted long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_long > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_long <= stall_long - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) < 70);
      end
   end

   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.detector_state, rsp_bus.falling, rsp_bus.fallen,
                rsp_bus.accel_magnitude, rsp_bus.falls_total, rsp_bus.false_alarms_total};
         responses_seen++;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (got.detector_state !== want.detector_state)
               $display("%0t: detector_state exp %0d got %0d", $time,
                        want.detector_state, got.detector_state);
            if (got.falling !== want.falling)
               $display("%0t: falling exp %0d got %0d", $time, want.falling, got.falling);
            if (got.fallen !== want.fallen)
               $display("%0t: fallen exp %0d got %0d", $time, want.fallen, got.fallen);
            if (got.accel_magnitude !== want.accel_magnitude)
               $display("%0t: accel_magnitude exp %0d got %0d", $time,
                        want.accel_magnitude, got.accel_magnitude);
            if (got.falls_total !== want.falls_total)
               $display("%0t: falls_total exp %0d got %0d", $time,
                        want.falls_total, got.falls_total);
            if (got.false_alarms_total !== want.false_alarms_total)
               $display("%0t: false_alarms_total exp %0d got %0d", $time,
                        want.false_alarms_total, got.false_alarms_total);
            if (got !== want) errors++;
         end
      end
   end

   task automatic send_request(logic func, logic signed [15:0] ax, logic signed [15:0] ay,
         logic signed [15:0] az, logic [31:0] now, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      repeat (g) @(posedge clock);
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.accel_x <= ax;
      req_bus.accel_y <= ay;
      req_bus.accel_z <= az;
      req_bus.time_ms <= now;
      do @(posedge clock); while (!req_bus.ready);
      pending_verdicts.push_back(detect_step(func, ax, ay, az, now));
      // drop valid for one cycle; the block is busy then anyway
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_FREE_FALL_LEVEL: lvl_free_fall = data[15:0];
         REG_IMPACT_LEVEL:    lvl_impact = data[15:0];
         REG_POST_WAIT:       wait_post = data;
         REG_FF_TIMEOUT:      timeout_ff = data;
         REG_ALERT_HOLD:      hold_alert = data;
         REG_QUIET_LIMIT:     limit_quiet = data;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] ff, logic [15:0] im, logic [31:0] pw,
         logic [31:0] to, logic [31:0] ho, logic [31:0] ql);
      drain();
      write_reg(REG_FREE_FALL_LEVEL, ff);
      write_reg(REG_IMPACT_LEVEL, im);
      write_reg(REG_POST_WAIT, pw);
      write_reg(REG_FF_TIMEOUT, to);
      write_reg(REG_ALERT_HOLD, ho);
      write_reg(REG_QUIET_LIMIT, ql);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rnd16();
      return 16'($urandom);
   endfunction

   // axis value near a target magnitude, spread on one axis
   function automatic logic signed [15:0] near(int target, int jitter);
      return 16'(target + $signed($urandom_range(2 * jitter)) - jitter);
   endfunction

   task automatic test_directed();
      logic [31:0] t;
      t = 32'd100;
      send_request(0, 0, 0, 0, t);
      send_request(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, t + 1);
      send_request(0, -16'sh8000, -16'sh8000, -16'sh8000, t + 2);
      send_request(0, -16'sh8000, 16'sh7fff, 0, t + 3);
      send_request(1, 16'sh1234, 0, 0, 32'hffff_ffff);
      send_request(0, 4096, 0, 0, 32'hffff_fff0);
      // free fall crossing the timestamp wrap, impact, post-fall, then a false alarm on the noisy window
      send_request(0, 100, 0, 0, 32'hffff_fff8);
      send_request(0, 16000, 0, 0, 32'h0000_0005);
      send_request(0, 4096, 0, 0, 32'h0000_0010);
      send_request(0, 4096, 0, 0, 32'h0000_1000);
      send_request(0, 4096, 0, 0, 32'h0000_2000);
      send_request(0, 4096, 0, 0, 32'h0001_0000);
      send_request(1, 0, 0, 0, 0);
      // free fall timeout as a false alarm, elapsed exactly at the limit first
      send_request(0, 0, 0, 0, 32'd5000);
      send_request(0, 0, 0, 0, 32'd7000);
      send_request(0, 0, 0, 0, 32'd7001);
      // noisy window after impact: false alarm
      send_request(0, 0, 0, 0, 32'd8000);
      send_request(0, 16'sh7fff, 0, 0, 32'd8001);
      send_request(0, 0, 0, 0, 32'd8002);
      send_request(0, 16'sh7fff, 16'sh7fff, 0, 32'd8003);
      send_request(1, -1, -1, -1, 32'd1);
   endtask

   task automatic random_burst(int n, logic [31:0] t0);
      logic [31:0] t;
      int k, kind;
      t = t0;
      k = 0;
      while (k < n) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_request(1, rnd16(), rnd16(), rnd16(), $urandom);
            k++;
         end else if (kind < 20) begin
            t = (kind < 12) ? $urandom : t + $urandom_range(500);
            send_request(0, rnd16(), rnd16(), rnd16(), t);
            k++;
         end else begin
            // fall sequence: rest, drop, impact, then a still stretch
            repeat ($urandom_range(3)) begin
               t += $urandom_range(50, 5);
               send_request(0, near(4096, 300), near(0, 300), near(0, 300), t);
               k++;
            end
            repeat ($urandom_range(4, 1)) begin
               t += $urandom_range(800, 5);
               send_request(0, near(0, 900), near(0, 900), near(0, 900), t);
               k++;
            end
            t += $urandom_range(100, 5);
            send_request(0, near(20000, 4000), near(0, 8000), near(0, 8000), t);
            k++;
            repeat ($urandom_range(8, 1)) begin
               t += $urandom_range(1500, 10);
               send_request(0, near(4096, 40), near(0, 40), near(0, 40), t);
               k++;
            end
         end
      end
   endtask

   task automatic test_back_pressure();
      logic [31:0] t;
      t = 32'd50;
      stall_long <= 300;
      repeat (12) begin
         t += 10;
         send_request(0, rnd16(), rnd16(), rnd16(), t, 1);
      end
      drain();
      random_burst(20, t);
   endtask

   initial begin
      reset = 1'b1;
      stall_long = 0;
      errors = 0;
      responses_seen = 0;
      req_bus.valid = 1'b0;
      req_bus.func = 1'b0;
      req_bus.accel_x = 0;
      req_bus.accel_y = 0;
      req_bus.accel_z = 0;
      req_bus.time_ms = 0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_FREE_FALL_LEVEL;
      csr_bus.data = 0;
      lvl_free_fall = FREE_FALL_LEVEL_RST;
      lvl_impact = IMPACT_LEVEL_RST;
      wait_post = POST_WAIT_RST;
      timeout_ff = FF_TIMEOUT_RST;
      hold_alert = HOLD_RST;
      limit_quiet = QUIET_LIMIT_RST;
      foreach (mag_hist[i]) mag_hist[i] = 0;
      hist_ptr = 0;
      mag_sum = 0;
      mag_sq_sum = 0;
      cur_phase = PH_NORMAL;
      phase_t0 = 0;
      fall_cnt = 0;
      false_cnt = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      random_burst(700, 32'd0);
      test_back_pressure();
      set_regs(16'hffff, 16'h0000, 32'd0, 32'd0, 32'd0, 32'hffff_ffff);
      random_burst(200, 32'd0);
      set_regs(16'h0000, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
      random_burst(150, 32'd0);
      set_regs(16'd3000, 16'd10000, 32'd300, 32'd1500, 32'd2000, 32'd400000);
      random_burst(450, 32'hffff_f000);
      drain();
      $display("Covered directed extremes, fall/false-alarm sequences and random samples;");
      $display("%0d responses checked over four register settings.", responses_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule

[fall_detector_state_machine.f]
sv/fdsm_pkg.sv
sv/fdsm_if.sv
sv/fdsm_ctrl.sv
sv/fdsm_dpath.sv
sv/fall_detector_state_machine.sv
tb/sv/tb_fall_detector_state_machine.sv
